/* hw/rtl/srd_pkg.sv */
package srd_pkg;

    // Payload store depth and derived widths
    localparam int MAX_PAYLOAD = 12;
    localparam int PAY_AW      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int IDX_W       = $clog2(MAX_PAYLOAD + 5);

    // Job queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Frame constants
    localparam logic [7:0] SYNC_PLAIN = 8'h55;
    localparam logic [7:0] SYNC_CRC   = 8'h42;
    localparam logic [7:0] CRC_POLY   = 8'h31;
    localparam logic [7:0] CRC_INIT   = 8'hFF;
    localparam logic [7:0] LEN_BIAS   = 8'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_MODE = 2'd0;
    localparam logic [1:0] CFG_CMD  = 2'd1;
    localparam logic [1:0] CFG_LEN  = 2'd2;

    // Input command codes
    localparam logic CMD_BYTE  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Result kinds and status codes
    localparam logic       KIND_PAYLOAD = 1'b0;
    localparam logic       KIND_STATUS  = 1'b1;
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_HDR   = 2'd1;
    localparam logic [1:0] ST_CRC       = 2'd2;

    typedef enum logic [1:0] {
        PH_HDR,
        PH_HDR_BAD,
        PH_BODY
    } t_phase;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DRAIN,
        BK_STAT
    } t_bk_state;

    typedef enum logic {
        JB_BAD_HDR,
        JB_FRAME
    } t_job_kind;

    typedef struct packed {
        logic       command;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic       kind;
        logic [7:0] payload_byte;
        logic [1:0] status;
        logic       last;
    } t_out_item;

    // One frame outcome handed from front to back
    typedef struct packed {
        t_job_kind        kind;
        logic             ok;
        logic [LEN_W-1:0] cnt;
    } t_job;

    // Payload store write port
    typedef struct packed {
        logic              en;
        logic [PAY_AW-1:0] addr;
        logic [7:0]        data;
    } t_store_wr;

    // Back-end status seen by the front
    typedef struct packed {
        logic busy;
    } t_bk_status;

    // CRC-8, MSB first, one byte
    function automatic logic [7:0] crc8_update(input logic [7:0] c, input logic [7:0] b);
        logic [7:0] x;
        x = c ^ b;
        for (int k = 0; k < 8; k++) begin
            if (x[7]) begin
                x = {x[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                x = {x[6:0], 1'b0};
            end
        end
        return x;
    endfunction

endpackage

/* hw/rtl/srd_front.sv */
module srd_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_idx,
    input  logic [7:0]             i_cfg_data,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  srd_pkg::t_in_item      i_item,
    output logic                   o_push,
    output srd_pkg::t_job          o_job,
    input  logic                   i_q_full,
    output srd_pkg::t_store_wr     o_wr,
    input  srd_pkg::t_bk_status    i_bk
);

    // Configuration registers
    logic       r_mode;
    logic [7:0] r_cmd;
    logic [3:0] r_len;

    // Frame tracking state
    srd_pkg::t_phase           r_phase, n_phase;
    logic [srd_pkg::IDX_W-1:0] r_idx, n_idx;
    logic [7:0]                r_crc, n_crc;
    logic [7:0]                r_rcrc, n_rcrc;

    logic                      acc, is_flush, m1, in_body;
    logic [7:0]                b, len8, len_code;
    logic                      len_over;
    logic [srd_pkg::LEN_W-1:0] eff;
    logic [srd_pkg::IDX_W-1:0] eff_x, hlast, idx_inc;
    logic                      byte_bad, hdr_bad, hdr_done, hdr_reject, hdr_fin0;
    logic                      body_end, body_last, fin, crc_hit, ok;
    logic [7:0]                crc_upd, crc_new;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_cmd  <= 8'd0;
            r_len  <= 4'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                srd_pkg::CFG_MODE: r_mode <= i_cfg_data[0];
                srd_pkg::CFG_CMD:  r_cmd  <= i_cfg_data;
                srd_pkg::CFG_LEN:  r_len  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Full queue stalls; body waits on a queued or draining job
    assign o_ready  = !i_q_full && !((r_phase == srd_pkg::PH_BODY) && i_bk.busy);
    assign acc      = i_valid && o_ready;
    assign is_flush = (i_item.command == srd_pkg::CMD_FLUSH);
    assign b        = i_item.rx_byte;
    assign m1       = r_mode;
    assign in_body  = (r_phase == srd_pkg::PH_BODY);

    // Length handling
    assign len8     = 8'(r_len);
    assign len_code = len8 + srd_pkg::LEN_BIAS;
    assign len_over = len8 > 8'(srd_pkg::MAX_PAYLOAD);
    assign eff      = len_over ? srd_pkg::LEN_W'(srd_pkg::MAX_PAYLOAD) : srd_pkg::LEN_W'(r_len);
    assign eff_x    = srd_pkg::IDX_W'(eff);
    assign hlast    = m1 ? srd_pkg::IDX_W'(3) : srd_pkg::IDX_W'(2);
    assign idx_inc  = r_idx + srd_pkg::IDX_W'(1);

    // Header byte check
    always_comb begin
        byte_bad = 1'b0;
        if (r_idx == '0) begin
            byte_bad = b != (m1 ? srd_pkg::SYNC_CRC : srd_pkg::SYNC_PLAIN);
        end else if (!m1) begin
            if (r_idx == srd_pkg::IDX_W'(1)) begin
                byte_bad = b != len_code;
            end else if (r_idx == srd_pkg::IDX_W'(2)) begin
                byte_bad = b != r_cmd;
            end
        end else begin
            if (r_idx == srd_pkg::IDX_W'(2)) begin
                byte_bad = b != len_code;
            end else if (r_idx == srd_pkg::IDX_W'(3)) begin
                byte_bad = b != r_cmd;
            end
        end
    end

    assign hdr_bad    = (r_phase == srd_pkg::PH_HDR_BAD) || byte_bad;
    assign hdr_done   = r_idx >= hlast;
    assign hdr_reject = hdr_done && (hdr_bad || len_over);
    assign hdr_fin0   = hdr_done && !hdr_reject && m1 && (eff == '0);

    assign body_end  = r_idx >= eff_x;
    assign body_last = m1 && !body_end && (idx_inc >= eff_x);
    assign fin       = in_body ? (body_end || body_last) : hdr_fin0;

    // CRC over length, command and payload
    assign crc_upd = srd_pkg::crc8_update(r_crc, b);
    assign crc_hit = m1 && (in_body ? !body_end
                                    : ((r_idx == srd_pkg::IDX_W'(2)) ||
                                       (r_idx == srd_pkg::IDX_W'(3))));
    assign crc_new = (!in_body && (r_idx == '0)) ? srd_pkg::CRC_INIT :
                     crc_hit ? crc_upd : r_crc;
    assign ok      = !m1 || (crc_new == r_rcrc);

    // Next state
    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        n_crc   = r_crc;
        n_rcrc  = r_rcrc;
        if (acc) begin
            if (is_flush) begin
                n_phase = srd_pkg::PH_HDR;
                n_idx   = '0;
                n_crc   = srd_pkg::CRC_INIT;
                n_rcrc  = 8'd0;
            end else if (!in_body) begin
                n_phase = hdr_bad ? srd_pkg::PH_HDR_BAD : srd_pkg::PH_HDR;
                n_idx   = idx_inc;
                n_crc   = crc_new;
                if (m1 && (r_idx == srd_pkg::IDX_W'(1))) begin
                    n_rcrc = b;
                end
                if (hdr_done) begin
                    if (hdr_reject || hdr_fin0) begin
                        n_phase = srd_pkg::PH_HDR;
                        n_idx   = '0;
                        n_crc   = srd_pkg::CRC_INIT;
                        n_rcrc  = 8'd0;
                    end else begin
                        n_phase = srd_pkg::PH_BODY;
                        n_idx   = '0;
                    end
                end
            end else if (fin) begin
                n_phase = srd_pkg::PH_HDR;
                n_idx   = '0;
                n_crc   = srd_pkg::CRC_INIT;
                n_rcrc  = 8'd0;
            end else begin
                n_idx = idx_inc;
                n_crc = crc_new;
            end
        end
    end

    // Outputs: job push and store write
    always_comb begin
        o_push     = acc && !is_flush && (fin || (!in_body && hdr_reject));
        o_job.kind = (!in_body && hdr_reject) ? srd_pkg::JB_BAD_HDR : srd_pkg::JB_FRAME;
        o_job.ok   = ok;
        o_job.cnt  = eff;
        o_wr.en    = acc && !is_flush && in_body && !body_end;
        o_wr.addr  = r_idx[srd_pkg::PAY_AW-1:0];
        o_wr.data  = b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= srd_pkg::PH_HDR;
            r_idx   <= '0;
            r_crc   <= srd_pkg::CRC_INIT;
            r_rcrc  <= 8'd0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_crc   <= n_crc;
            r_rcrc  <= n_rcrc;
        end
    end

endmodule

/* hw/rtl/srd_queue.sv */
module srd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  srd_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_valid,
    output srd_pkg::t_job o_job,
    input  logic          i_pop
);

    srd_pkg::t_job            r_slot [srd_pkg::Q_DEPTH];
    logic [srd_pkg::Q_AW-1:0] r_wp, r_rp;
    logic [srd_pkg::Q_CW-1:0] r_cnt;
    logic                     do_push, do_pop;

    assign o_full  = (r_cnt == srd_pkg::Q_CW'(srd_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_slot[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Slot storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == srd_pkg::Q_AW'(srd_pkg::Q_DEPTH - 1)) ? '0
                                                                      : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == srd_pkg::Q_AW'(srd_pkg::Q_DEPTH - 1)) ? '0
                                                                      : r_rp + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* hw/rtl/srd_back.sv */
module srd_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  srd_pkg::t_store_wr    i_wr,
    input  logic                  i_q_valid,
    input  srd_pkg::t_job         i_q_job,
    output logic                  o_pop,
    output srd_pkg::t_bk_status   o_bk,
    output logic                  o_valid,
    input  logic                  i_ready,
    output srd_pkg::t_out_item    o_item
);

    logic [7:0] r_store [srd_pkg::MAX_PAYLOAD];

    srd_pkg::t_bk_state        r_state, n_state;
    srd_pkg::t_job             r_job;
    logic [srd_pkg::PAY_AW-1:0] r_rd;
    logic                      r_ovalid;
    srd_pkg::t_out_item        r_out;

    logic       out_free, last_rd, emit_byte, emit_stat;
    logic [1:0] st_code;

    assign out_free = !r_ovalid || i_ready;
    assign last_rd  = (srd_pkg::LEN_W'(r_rd) + srd_pkg::LEN_W'(1)) == r_job.cnt;

    always_comb begin
        if (r_job.kind == srd_pkg::JB_BAD_HDR) begin
            st_code = srd_pkg::ST_BAD_HDR;
        end else if (r_job.ok) begin
            st_code = srd_pkg::ST_OK;
        end else begin
            st_code = srd_pkg::ST_CRC;
        end
    end

    // Payload store
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_store[i_wr.addr] <= i_wr.data;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            srd_pkg::BK_IDLE: begin
                if (i_q_valid) begin
                    if ((i_q_job.kind == srd_pkg::JB_FRAME) && i_q_job.ok &&
                        (i_q_job.cnt != '0)) begin
                        n_state = srd_pkg::BK_DRAIN;
                    end else begin
                        n_state = srd_pkg::BK_STAT;
                    end
                end
            end
            srd_pkg::BK_DRAIN: begin
                if (out_free && last_rd) begin
                    n_state = srd_pkg::BK_STAT;
                end
            end
            srd_pkg::BK_STAT: begin
                if (out_free) begin
                    n_state = srd_pkg::BK_IDLE;
                end
            end
            default: n_state = srd_pkg::BK_IDLE;
        endcase
    end

    // State outputs; busy also covers a job still waiting in the queue,
    // whose payload must not be overwritten before it drains
    always_comb begin
        o_pop     = (r_state == srd_pkg::BK_IDLE) && i_q_valid;
        emit_byte = (r_state == srd_pkg::BK_DRAIN) && out_free;
        emit_stat = (r_state == srd_pkg::BK_STAT) && out_free;
        o_bk.busy = (r_state != srd_pkg::BK_IDLE) || i_q_valid;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= srd_pkg::BK_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit_byte || emit_stat) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Job, read index and output register
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_q_job;
            r_rd  <= '0;
        end else if (emit_byte) begin
            r_rd <= r_rd + 1'b1;
        end
        if (emit_byte) begin
            r_out.kind         <= srd_pkg::KIND_PAYLOAD;
            r_out.payload_byte <= r_store[r_rd];
            r_out.status       <= srd_pkg::ST_OK;
            r_out.last         <= 1'b0;
        end else if (emit_stat) begin
            r_out.kind         <= srd_pkg::KIND_STATUS;
            r_out.payload_byte <= 8'd0;
            r_out.status       <= st_code;
            r_out.last         <= 1'b1;
        end
    end

    assign o_valid = r_ovalid;
    assign o_item  = r_out;

`ifndef SYNTHESIS
    a_drain_ok_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srd_pkg::BK_DRAIN) |-> ((r_job.kind == srd_pkg::JB_FRAME) && r_job.ok))
        else $error("drain entered for a job without released payload");
    a_drain_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srd_pkg::BK_DRAIN) |-> (srd_pkg::LEN_W'(r_rd) < r_job.cnt))
        else $error("payload read index past frame length");
    a_byte_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_byte |=> (r_ovalid && (r_out.kind == srd_pkg::KIND_PAYLOAD)))
        else $error("drained byte not presented");
`endif

endmodule

/* hw/rtl/serial_response_deframer.sv */
// Channel   Direction  Handshake                    Payload
// rx        in         i_rx_valid / o_rx_ready      i_rx_item  (command, rx_byte)
// rsp       out        o_rsp_valid / i_rsp_ready    o_rsp_item (kind, payload_byte, status, last)
// cfg       in         i_cfg_we (no wait)           i_cfg_idx, i_cfg_data
//
// Bytes are taken one per cycle, but body bytes wait while any job is queued or
// draining and header bytes while the two-entry job queue is full. The first result
// of a frame passes the job queue, drain job register and output register after its
// last byte is accepted; a good frame gives count payload results and a status result,
// one per cycle while i_rsp_ready is high; a bad header or CRC gives one status result.
// Reset is synchronous, active low; the payload store is not cleared.
module serial_response_deframer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [7:0]           i_cfg_data,
    input  logic                 i_rx_valid,
    output logic                 o_rx_ready,
    input  srd_pkg::t_in_item    i_rx_item,
    output logic                 o_rsp_valid,
    input  logic                 i_rsp_ready,
    output srd_pkg::t_out_item   o_rsp_item
);

    logic                 push, q_full, q_valid, pop;
    srd_pkg::t_job        push_job, q_job;
    srd_pkg::t_store_wr   wr;
    srd_pkg::t_bk_status  bk;

    srd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_rx_valid),
        .o_ready    (o_rx_ready),
        .i_item     (i_rx_item),
        .o_push     (push),
        .o_job      (push_job),
        .i_q_full   (q_full),
        .o_wr       (wr),
        .i_bk       (bk)
    );

    srd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (pop)
    );

    srd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr),
        .i_q_valid (q_valid),
        .i_q_job   (q_job),
        .o_pop     (pop),
        .o_bk      (bk),
        .o_valid   (o_rsp_valid),
        .i_ready   (i_rsp_ready),
        .o_item    (o_rsp_item)
    );

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_full)
        else $error("job pushed into full queue");
    a_no_write_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr.en |-> (!bk.busy && !q_valid))
        else $error("payload store written while a frame drains");
    a_payload_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && (o_rsp_item.kind == srd_pkg::KIND_PAYLOAD)) |-> bk.busy)
        else $error("payload result pending with drain side idle");
`endif

endmodule

/* tb/sv/srd_checker.sv */
// Watches the rx, rsp and cfg ports, predicts every response transaction and
// compares it with what the deframer returns.
module srd_checker
    import srd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    input  logic       i_rx_valid,
    input  logic       i_rx_ready,
    input  t_in_item   i_rx_item,
    input  logic       i_rsp_valid,
    input  logic       i_rsp_ready,
    input  t_out_item  i_rsp_item,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow registers
    logic       cfg_mode;
    logic [7:0] cfg_cmd;
    logic [3:0] cfg_len;

    // Deframer state
    t_phase      phase;
    int unsigned byte_pos;
    logic [7:0]  crc_run;
    logic [7:0]  crc_rx;
    logic [7:0]  pay_mem [MAX_PAYLOAD];

    t_out_item rsp_expect_q [$];
    int        fails;

    // CRC-8, polynomial 0x31, one byte MSB first
    function automatic logic [7:0] crc8_step(input logic [7:0] c, input logic [7:0] b);
        logic [7:0] r;
        r = c ^ b;
        repeat (8) begin
            r = {r[6:0], 1'b0} ^ (r[7] ? CRC_POLY : 8'h00);
        end
        return r;
    endfunction

    function automatic int body_len();
        return (cfg_len > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(cfg_len);
    endfunction

    function void restart_frame();
        phase    = PH_HDR;
        byte_pos = 0;
        crc_run  = CRC_INIT;
        crc_rx   = 8'h00;
    endfunction

    function void push_rsp(input logic kind, input logic [7:0] pb, input logic [1:0] st,
                           input logic last);
        t_out_item r;
        r.kind         = kind;
        r.payload_byte = pb;
        r.status       = st;
        r.last         = last;
        rsp_expect_q.push_back(r);
    endfunction

    // Frame end: payload bytes then ok, or a lone CRC error
    function void close_frame();
        int n;
        n = body_len();
        if (cfg_mode == 1'b0 || crc_run == crc_rx) begin
            for (int i = 0; i < n; i++) begin
                push_rsp(KIND_PAYLOAD, pay_mem[i], ST_OK, 1'b0);
            end
            push_rsp(KIND_STATUS, 8'h00, ST_OK, 1'b1);
        end else begin
            push_rsp(KIND_STATUS, 8'h00, ST_CRC, 1'b1);
        end
        restart_frame();
    endfunction

    // One accepted rx transaction, live register values
    function void predict_rx(input t_in_item it);
        logic [7:0]  b;
        logic [7:0]  len_code;
        logic        bad;
        int unsigned hlen;
        int unsigned p;
        int unsigned l;
        b        = it.rx_byte;
        len_code = {4'h0, cfg_len} + LEN_BIAS;
        bad      = 1'b0;
        if (it.command == CMD_FLUSH) begin
            restart_frame();
            return;
        end
        if (phase != PH_BODY) begin
            hlen = cfg_mode ? 4 : 3;
            if (byte_pos == 0) begin
                crc_run = CRC_INIT;
                bad     = (b != (cfg_mode ? SYNC_CRC : SYNC_PLAIN));
            end else if (!cfg_mode) begin
                if (byte_pos == 1) bad = (b != len_code);
                else if (byte_pos == 2) bad = (b != cfg_cmd);
            end else begin
                if (byte_pos == 1) begin
                    crc_rx = b;
                end else if (byte_pos == 2) begin
                    bad     = (b != len_code);
                    crc_run = crc8_step(crc_run, b);
                end else if (byte_pos == 3) begin
                    bad     = (b != cfg_cmd);
                    crc_run = crc8_step(crc_run, b);
                end
            end
            if (bad) phase = PH_HDR_BAD;
            byte_pos++;
            if (byte_pos < hlen) return;
            if (phase == PH_HDR_BAD || cfg_len > MAX_PAYLOAD) begin
                push_rsp(KIND_STATUS, 8'h00, ST_BAD_HDR, 1'b1);
                restart_frame();
                return;
            end
            phase    = PH_BODY;
            byte_pos = 0;
            // zero payload in CRC mode ends on the command byte
            if (cfg_mode && body_len() == 0) close_frame();
            return;
        end
        p = byte_pos;
        l = body_len();
        if (p >= l) begin
            close_frame();
            return;
        end
        pay_mem[p] = b;
        if (cfg_mode) crc_run = crc8_step(crc_run, b);
        byte_pos = p + 1;
        if (cfg_mode && p + 1 >= l) close_frame();
    endfunction

    function void check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            fails++;
        end
    endfunction

    // Sample all channels at the rising edge
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            cfg_mode = 1'b0;
            cfg_cmd  = 8'h00;
            cfg_len  = 4'h0;
            restart_frame();
            rsp_expect_q.delete();
            fails = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODE: cfg_mode = i_cfg_data[0];
                    CFG_CMD:  cfg_cmd  = i_cfg_data;
                    CFG_LEN:  cfg_len  = i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_rx_valid && i_rx_ready) predict_rx(i_rx_item);
            if (i_rsp_valid && i_rsp_ready) begin
                if (rsp_expect_q.size() == 0) begin
                    $error("unexpected response: kind %0d byte %0d status %0d last %0d",
                           i_rsp_item.kind, i_rsp_item.payload_byte, i_rsp_item.status,
                           i_rsp_item.last);
                    fails++;
                end else begin
                    want = rsp_expect_q.pop_front();
                    check_field("kind", want.kind, i_rsp_item.kind);
                    check_field("payload_byte", want.payload_byte, i_rsp_item.payload_byte);
                    check_field("status", want.status, i_rsp_item.status);
                    check_field("last", want.last, i_rsp_item.last);
                end
            end
        end
        o_fail_count = fails;
        o_pending    = rsp_expect_q.size();
    end

endmodule

/* tb/sv/tb_serial_response_deframer.sv */
// Stimulus and verdict for the serial response deframer.
module tb_serial_response_deframer;
    import srd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 20;

    typedef enum int {
        FR_GOOD,
        FR_BAD_SYNC,
        FR_BAD_LEN,
        FR_BAD_CMD,
        FR_BAD_CRC,
        FR_CUT
    } frame_variant_e;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [7:0] i_cfg_data;
    logic      i_rx_valid;
    logic      o_rx_ready;
    t_in_item  i_rx_item;
    logic      o_rsp_valid;
    logic      i_rsp_ready;
    t_out_item o_rsp_item;

    int chk_fails;
    int chk_pending;

    // Register values as last written, used to build frames
    logic       cur_mode;
    logic [7:0] cur_cmd;
    logic [3:0] cur_len;

    int rx_gap_pct    = 0;
    int rsp_stall_pct = 0;
    int rsp_hold_len  = 0;
    int rx_sent       = 0;
    int idle_cycles   = 0;

    always #6 i_clk = ~i_clk;

    serial_response_deframer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_rx_valid (i_rx_valid),
        .o_rx_ready (o_rx_ready),
        .i_rx_item  (i_rx_item),
        .o_rsp_valid(o_rsp_valid),
        .i_rsp_ready(i_rsp_ready),
        .o_rsp_item (o_rsp_item)
    );

    srd_checker u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_rx_valid  (i_rx_valid),
        .i_rx_ready  (o_rx_ready),
        .i_rx_item   (i_rx_item),
        .i_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .i_rsp_item  (o_rsp_item),
        .o_fail_count(chk_fails),
        .o_pending   (chk_pending)
    );

    // Watchdog: cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_rx_valid && o_rx_ready) || (o_rsp_valid && i_rsp_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Response side: random stalls, or a long hold-off on request
    initial begin
        i_rsp_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rsp_hold_len > 0) begin
                i_rsp_ready <= 1'b0;
                repeat (rsp_hold_len) @(negedge i_clk);
                rsp_hold_len = 0;
            end else begin
                i_rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so a following transaction can go back to back.
    task automatic send_rx(input logic cmd, input logic [7:0] b);
        while ($urandom_range(99) < rx_gap_pct) begin
            i_rx_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_rx_valid        <= 1'b1;
        i_rx_item.command <= cmd;
        i_rx_item.rx_byte <= b;
        do @(posedge i_clk); while (!o_rx_ready);
        rx_sent++;
        @(negedge i_clk);
    endtask

    // Drop valid, wait for every response, then let the block go quiet
    task automatic settle();
        i_rx_valid <= 1'b0;
        do @(negedge i_clk); while (chk_pending != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_MODE: cur_mode = data[0];
            CFG_CMD:  cur_cmd  = data;
            CFG_LEN:  cur_len  = data[3:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_config(input logic m, input logic [7:0] c, input logic [3:0] l);
        write_reg(CFG_MODE, {7'h00, m});
        write_reg(CFG_CMD, c);
        write_reg(CFG_LEN, {4'h0, l});
    endtask

    // Build one frame for the current registers, optionally broken, and send it
    task automatic send_frame(input frame_variant_e v, input bit extremes);
        logic [7:0] pay [$];
        logic [7:0] seq [$];
        logic [7:0] crc;
        logic [7:0] len_code;
        logic [7:0] flip;
        int         n;
        int         hsz;
        int         stop_at;
        bit         hdr_bad;
        n        = (cur_len > MAX_PAYLOAD) ? 0 : int'(cur_len);
        len_code = {4'h0, cur_len} + LEN_BIAS;
        flip     = 8'h01 << $urandom_range(7);
        for (int i = 0; i < n; i++) begin
            if (extremes) pay.push_back((i % 2) ? 8'hFF : 8'h00);
            else pay.push_back(8'($urandom_range(255)));
        end
        crc = u_chk.crc8_step(CRC_INIT, len_code);
        crc = u_chk.crc8_step(crc, cur_cmd);
        foreach (pay[i]) crc = u_chk.crc8_step(crc, pay[i]);
        if (cur_mode) begin
            seq.push_back(SYNC_CRC);
            seq.push_back(crc);
        end else begin
            seq.push_back(SYNC_PLAIN);
        end
        seq.push_back(len_code);
        seq.push_back(cur_cmd);
        hsz     = seq.size();
        hdr_bad = (cur_len > MAX_PAYLOAD);
        case (v)
            FR_BAD_SYNC: begin seq[0] ^= flip; hdr_bad = 1'b1; end
            FR_BAD_LEN:  begin seq[hsz-2] ^= flip; hdr_bad = 1'b1; end
            FR_BAD_CMD:  begin seq[hsz-1] ^= flip; hdr_bad = 1'b1; end
            FR_BAD_CRC:  if (cur_mode) seq[1] ^= flip;
            default: ;
        endcase
        // after a bad header the block hunts for sync again, so stop here
        if (!hdr_bad) begin
            foreach (pay[i]) seq.push_back(pay[i]);
            if (!cur_mode) seq.push_back(8'($urandom_range(255)));
        end
        stop_at = (v == FR_CUT) ? $urandom_range(seq.size() - 1, 1) : seq.size();
        for (int i = 0; i < stop_at; i++) send_rx(CMD_BYTE, seq[i]);
        if (v == FR_CUT) send_rx(CMD_FLUSH, 8'($urandom_range(255)));
    endtask

    // Line noise, then a flush to resynchronize
    task automatic send_noise();
        int n;
        n = $urandom_range(4, 1);
        repeat (n) begin
            send_rx(($urandom_range(3) == 0) ? CMD_FLUSH : CMD_BYTE, 8'($urandom_range(255)));
        end
        send_rx(CMD_FLUSH, 8'($urandom_range(255)));
    endtask

    task automatic random_config();
        int r;
        logic [7:0] c;
        logic [3:0] l;
        r = $urandom_range(99);
        c = (r < 20) ? 8'h00 : (r < 40) ? 8'hFF : 8'($urandom_range(255));
        r = $urandom_range(99);
        if (r < 10) l = 4'd12;
        else if (r < 18) l = 4'($urandom_range(15, 13));
        else l = 4'($urandom_range(4));
        set_config(1'($urandom_range(1)), c, l);
    endtask

    initial begin
        int target;
        int r;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_MODE;
        i_cfg_data = 8'h00;
        i_rx_valid = 1'b0;
        i_rx_item  = '0;
        cur_mode   = 1'b0;
        cur_cmd    = 8'h00;
        cur_len    = 4'h0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: plain frame with extreme payload, flush, bad header
        set_config(1'b0, 8'hA5, 4'd2);
        send_frame(FR_GOOD, 1'b1);
        send_frame(FR_CUT, 1'b0);
        send_frame(FR_BAD_LEN, 1'b0);
        settle();

        // Length register lowered in the middle of the body
        set_config(1'b0, 8'h00, 4'd4);
        send_rx(CMD_BYTE, SYNC_PLAIN);
        send_rx(CMD_BYTE, 8'h08);
        send_rx(CMD_BYTE, 8'h00);
        send_rx(CMD_BYTE, 8'hC3);
        send_rx(CMD_BYTE, 8'h3C);
        settle();
        write_reg(CFG_LEN, 8'd1);
        send_rx(CMD_BYTE, 8'h99);
        settle();

        // CRC mode: zero payload, bad CRC, length above the store
        set_config(1'b1, 8'hFF, 4'd0);
        send_frame(FR_GOOD, 1'b0);
        send_frame(FR_BAD_CRC, 1'b0);
        settle();
        write_reg(CFG_LEN, 8'd15);
        send_frame(FR_GOOD, 1'b0);
        settle();

        // Long receiver hold-off while frames keep coming
        set_config(1'b1, 8'h3C, 4'd3);
        rsp_hold_len = 300;
        repeat (5) send_frame(FR_GOOD, 1'b0);
        settle();

        // Random frames under each idling pattern
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin rx_gap_pct = 0;  rsp_stall_pct = 0;  end
                1: begin rx_gap_pct = 50; rsp_stall_pct = 0;  end
                2: begin rx_gap_pct = 0;  rsp_stall_pct = 50; end
                default: begin rx_gap_pct = 13; rsp_stall_pct = 13; end
            endcase
            repeat (2) begin
                settle();
                random_config();
                target = rx_sent + 6;
                while (rx_sent < target) begin
                    r = $urandom_range(99);
                    if (r < 70) send_frame(FR_GOOD, 1'b0);
                    else if (r < 85) send_frame(frame_variant_e'($urandom_range(4, 1)), 1'b0);
                    else if (r < 92) send_frame(FR_CUT, 1'b0);
                    else send_noise();
                end
            end
        end

        settle();
        repeat (30) @(negedge i_clk);
        if (chk_fails == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* serial_response_deframer.f */
hw/rtl/srd_pkg.sv
hw/rtl/srd_front.sv
hw/rtl/srd_queue.sv
hw/rtl/srd_back.sv
hw/rtl/serial_response_deframer.sv
tb/sv/srd_checker.sv
tb/sv/tb_serial_response_deframer.sv
